// ----- design/assert_macros.svh -----
// Assertion macros included by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/mcsp_pkg.sv -----
// Package: pan codes, per-item setup struct and small arithmetic helpers.
package mcsp_pkg;

    localparam int SLOTS         = 15;
    localparam int MAX_CHIPS_DEF = 15;
    localparam int CODES_W       = 2 * SLOTS;

    // pan codes
    localparam logic [1:0] PAN_L    = 2'd0;
    localparam logic [1:0] PAN_C    = 2'd1;
    localparam logic [1:0] PAN_R    = 2'd2;
    localparam logic [1:0] PAN_NONE = 2'd3;

    // layouts
    localparam logic [1:0] LAY_STD   = 2'd0;
    localparam logic [1:0] LAY_LCR   = 2'd1;
    localparam logic [1:0] LAY_CFST  = 2'd2;
    localparam logic [1:0] LAY_ALLC  = 2'd3;

    // modes
    localparam logic [1:0] MODE_DIRECT  = 2'd0;
    localparam logic [1:0] MODE_REVERSE = 2'd1;
    localparam logic [1:0] MODE_GROUP   = 2'd2;
    localparam logic [1:0] MODE_SPREAD  = 2'd3;

    // group-mode block rules
    localparam logic [3:0] GROUP_SPLIT = 4'd9;  // one group up to this count
    localparam logic [3:0] GROUP_HEAD  = 4'd6;  // first group size above it
    localparam logic [3:0] TRIPLE_RUN  = 4'd3;  // odd center-first runs of three
    localparam logic [3:0] PAIR_COUNT  = 4'd2;

    // derived per-item values, registered once before the slot sweep
    typedef struct packed {
        logic [1:0] layout;
        logic [1:0] mode;
        logic [3:0] n;      // clamped chip count
        logic [3:0] lc3;    // n / 3
        logic [3:0] cc;     // n - 2 * lc3
        logic [3:0] g1;     // group mode, first group size
        logic [3:0] lca;
        logic [3:0] cca;
        logic [3:0] lcb;
        logic [3:0] ccb;
        logic       all_c;  // one chip or fully centered
    } setup_t;

    // v / 3 for v < 32 via reciprocal: v * 11 >> 5 is exact in that range
    function automatic logic [3:0] div3(input logic [4:0] v);
        logic [8:0] p;
        p = 9'(v) * 9'd11;
        return p[8:5];
    endfunction

    function automatic logic [1:0] mod3(input logic [3:0] v);
        logic [5:0] t;
        t = 6'(div3({1'b0, v})) * 6'd3;
        return 2'(6'(v) - t);
    endfunction

endpackage

// ----- design/mcsp_slot_code.sv -----
// Slot code unit: pan code of one slot from the per-item setup.
module mcsp_slot_code (
    input  mcsp_pkg::setup_t   setup,
    input  logic [3:0]         slot_idx,
    output logic [1:0]         code
);
    import mcsp_pkg::*;

    logic [3:0] k;
    logic [3:0] j_cf;     // offset past the center block
    logic [3:0] j_grp;    // offset inside the active LCR group
    logic [3:0] grp_lc;
    logic [3:0] grp_cc;
    logic [3:0] lc_cc;
    logic [3:0] two_lc;
    logic [3:0] half_up;
    logic [3:0] j_tail;
    logic [1:0] k_mod3;

    always_comb
    begin
        k       = slot_idx;
        j_cf    = 4'(k - setup.cc);
        lc_cc   = 4'(setup.lc3 + setup.cc);
        two_lc  = 4'({setup.lc3, 1'b0});
        half_up = 4'(({1'b0, setup.n} + 5'd1) >> 1);
        k_mod3  = mod3(k);
        j_tail  = 4'(j_cf - 4'(PAIR_COUNT * TRIPLE_RUN));
        if (k < setup.g1)
        begin
            j_grp  = k;
            grp_lc = setup.lca;
            grp_cc = setup.cca;
        end
        else
        begin
            j_grp  = 4'(k - setup.g1);
            grp_lc = setup.lcb;
            grp_cc = setup.ccb;
        end

        code = PAN_C;
        if (k >= setup.n)
            code = PAN_NONE;
        else if (setup.all_c)
            code = PAN_C;
        else
        begin
            case (setup.mode)
                MODE_DIRECT:
                begin
                    case (setup.layout)
                        LAY_STD:  code = k[0] ? PAN_R : PAN_L;
                        LAY_LCR:  code = k_mod3;
                        LAY_CFST: code = (k < setup.cc) ? PAN_C : (j_cf[0] ? PAN_R : PAN_L);
                        default:  code = PAN_C;
                    endcase
                end
                MODE_REVERSE:
                begin
                    case (setup.layout)
                        LAY_STD:  code = k[0] ? PAN_L : PAN_R;
                        LAY_LCR:  code = (k_mod3 == PAN_L) ? PAN_R :
                                         (k_mod3 == PAN_R) ? PAN_L : PAN_C;
                        // swapped sides moved ahead, center block moved behind
                        LAY_CFST: code = (k < two_lc) ? (k[0] ? PAN_L : PAN_R) : PAN_C;
                        default:  code = PAN_C;
                    endcase
                end
                MODE_GROUP:
                begin
                    case (setup.layout)
                        LAY_STD:
                            if (setup.n == 4'(PAIR_COUNT))
                                code = k[0] ? PAN_R : PAN_L;
                            else
                                code = k[1] ? PAN_R : PAN_L;
                        LAY_LCR:
                            if (j_grp < grp_lc)
                                code = PAN_L;
                            else if (j_grp < 4'(grp_lc + grp_cc))
                                code = PAN_C;
                            else
                                code = PAN_R;
                        LAY_CFST:
                            if (k < setup.cc)
                                code = PAN_C;
                            else if (setup.lc3 == 4'd1)
                                code = (j_cf == 4'd0) ? PAN_L : PAN_R;
                            else if (setup.lc3[0])
                            begin
                                // odd side count: runs of three, then pairs
                                if (j_cf < TRIPLE_RUN)
                                    code = PAN_L;
                                else if (j_cf < 4'(PAIR_COUNT * TRIPLE_RUN))
                                    code = PAN_R;
                                else
                                    code = j_tail[1] ? PAN_R : PAN_L;
                            end
                            else
                                code = j_cf[1] ? PAN_R : PAN_L;
                        default: code = PAN_C;
                    endcase
                end
                default:
                begin
                    case (setup.layout)
                        LAY_STD:  code = (k < half_up) ? PAN_L : PAN_R;
                        LAY_LCR:  code = (k < setup.lc3) ? PAN_L :
                                         (k < lc_cc) ? PAN_C : PAN_R;
                        LAY_CFST: code = (k < setup.cc) ? PAN_C :
                                         (k < lc_cc) ? PAN_L : PAN_R;
                        default:  code = PAN_C;
                    endcase
                end
            endcase
        end
    end

endmodule

// ----- design/multi_chip_stereo_pan_map.sv -----
// Top level: multi-chip stereo pan map, one slot per cycle through a shared code unit.
// An input beat passes through a setup state, the 15-slot sweep and a hand-off state that
// moves the result into the output register once that register is free or draining.
// A new item is taken only after the last result has been handed off.
// in_ready is high in idle, also while a finished result waits in the output register.
// Reset (rst_n, async, active low) clears the sequencer state, data registers and out_valid.
module multi_chip_stereo_pan_map #(
    parameter int MAX_CHIPS = mcsp_pkg::MAX_CHIPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    layout,
    input  logic [1:0]                    mode,
    input  logic [3:0]                    chip_count,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mcsp_pkg::CODES_W-1:0]  pan_codes,
    output logic [3:0]                    used_count
);
    import mcsp_pkg::*;

    `include "assert_macros.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_FINISH
    } state_t;

    localparam logic [3:0] LAST_SLOT = 4'(SLOTS - 1);

    state_t             state_reg, state_next;
    logic [3:0]         slot_reg, slot_next;
    logic [1:0]         layout_reg, layout_next;
    logic [1:0]         mode_reg, mode_next;
    logic [3:0]         count_reg, count_next;
    setup_t             setup_reg, setup_next;
    logic [CODES_W-1:0] acc_reg, acc_next;
    logic               out_valid_reg, out_valid_next;
    logic [CODES_W-1:0] codes_reg, codes_next;
    logic [3:0]         used_reg, used_next;

    // setup arithmetic on 4-bit values, widened to 5 bits for the divide by three
    setup_t     setup_calc;
    logic [3:0] n_clamp;
    logic [3:0] g2;
    logic [1:0] slot_code;
    logic       in_beat;
    logic       out_beat;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_beat   = in_valid && in_ready;
    assign out_beat  = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign pan_codes = codes_reg;
    assign used_count = used_reg;

    always_comb
    begin
        n_clamp = (count_reg > 4'(MAX_CHIPS)) ? 4'(MAX_CHIPS) : count_reg;
        setup_calc.layout = layout_reg;
        setup_calc.mode   = mode_reg;
        setup_calc.n      = n_clamp;
        setup_calc.lc3    = div3({1'b0, n_clamp});
        setup_calc.cc     = 4'(n_clamp - {setup_calc.lc3[2:0], 1'b0});
        setup_calc.g1     = (n_clamp <= GROUP_SPLIT) ? n_clamp : GROUP_HEAD;
        g2                = 4'(n_clamp - setup_calc.g1);
        // group size g: lc = (g + 1) / 3, cc = g - 2 * lc
        setup_calc.lca    = div3(5'(setup_calc.g1) + 5'd1);
        setup_calc.cca    = 4'(setup_calc.g1 - {setup_calc.lca[2:0], 1'b0});
        setup_calc.lcb    = div3(5'(g2) + 5'd1);
        setup_calc.ccb    = 4'(g2 - {setup_calc.lcb[2:0], 1'b0});
        setup_calc.all_c  = (n_clamp == 4'd1) || (layout_reg == LAY_ALLC);
    end

    // shared slot code unit
    mcsp_slot_code u_slot (
        .setup    (setup_reg),
        .slot_idx (slot_reg),
        .code     (slot_code)
    );

    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        layout_next    = layout_reg;
        mode_next      = mode_reg;
        count_next     = count_reg;
        setup_next     = setup_reg;
        acc_next       = acc_reg;
        codes_next     = codes_reg;
        used_next      = used_reg;
        out_valid_next = out_beat ? 1'b0 : out_valid_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    layout_next = layout;
                    mode_next   = mode;
                    count_next  = chip_count;
                    state_next  = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                setup_next = setup_calc;
                acc_next   = '1;          // every slot starts unused
                slot_next  = 4'd0;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                acc_next[{slot_reg, 1'b0} +: 2] = slot_code;
                slot_next = 4'(slot_reg + 4'd1);
                if (slot_reg == LAST_SLOT)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hand off once the output register is free or draining
                if (!out_valid_reg || out_ready)
                begin
                    codes_next     = acc_reg;
                    used_next      = setup_reg.n;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
            layout_reg    <= '0;
            mode_reg      <= '0;
            count_reg     <= '0;
            setup_reg     <= '0;
            acc_reg       <= '0;
            codes_reg     <= '0;
            used_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
            layout_reg    <= layout_next;
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            setup_reg     <= setup_next;
            acc_reg       <= acc_next;
            codes_reg     <= codes_next;
            used_reg      <= used_next;
        end
    end

    // a taken beat keeps the block busy for the setup cycle
    `ASSERT_NEXT(a_busy_after_beat, in_beat, !in_ready, "in_ready high right after input beat")

    // the sweep ends on the last slot
    `ASSERT_NEXT(a_sweep_end, (state_reg == ST_RUN) && (slot_reg == LAST_SLOT),
        state_reg == ST_FINISH, "slot sweep did not finish")

    // reported count never exceeds the clamp
    `ASSERT_IMPL(a_count_clamped, out_valid, used_count <= 4'(MAX_CHIPS),
        "used_count above MAX_CHIPS")

    // no chips: every slot unused
    `ASSERT_IMPL(a_zero_unused, out_valid && (used_count == 4'd0), pan_codes == '1,
        "zero chips but a slot is used")

endmodule

// ----- bench/tb_multi_chip_stereo_pan_map.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the multi-chip stereo pan map block.
module tb_multi_chip_stereo_pan_map;

    import mcsp_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int IDLE_PCT      = 17;     // chance of a gap or stall per cycle
    localparam int RANDOM_BEATS  = 1750;
    localparam int HOLD_CYCLES   = 400;    // one long output hold-off
    localparam int HOLD_AT       = 60;     // results seen before the hold-off
    localparam int STEADY_LO     = 400;    // beat window run with no gaps at all
    localparam int STEADY_HI     = 800;
    localparam int DRAIN_CYCLES  = 40;     // settle time after the last expected result
    localparam int WATCHDOG      = 4000;   // cycles with no beat on either side
    localparam int MAX_REPORTS   = 10;

    // one result beat
    typedef struct packed {
        logic [CODES_W-1:0] codes;
        logic [3:0]         used;
    } pan_result_t;

    // directed stimulus row; known rows carry a typed-in result
    typedef struct packed {
        logic [1:0]         lay;
        logic [1:0]         md;
        logic [3:0]         cnt;
        logic               known;
        logic [CODES_W-1:0] codes;
        logic [3:0]         used;
    } stim_row_t;

    localparam int N_DIRECTED = 23;

    // All-unused, single-center and all-center words are easy to write by
    // hand, as are the plain alternating L/R maps at full count.
    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{LAY_STD,  MODE_DIRECT,  4'd0,  1'b1, 30'h3FFFFFFF, 4'd0},   // zero chips
        '{LAY_CFST, MODE_SPREAD,  4'd0,  1'b1, 30'h3FFFFFFF, 4'd0},
        '{LAY_STD,  MODE_REVERSE, 4'd1,  1'b1, 30'h3FFFFFFD, 4'd1},   // one chip
        '{LAY_LCR,  MODE_GROUP,   4'd1,  1'b1, 30'h3FFFFFFD, 4'd1},
        '{LAY_ALLC, MODE_GROUP,   4'd15, 1'b1, 30'h15555555, 4'd15},  // fully centered
        '{LAY_ALLC, MODE_REVERSE, 4'd2,  1'b1, 30'h3FFFFFF5, 4'd2},
        '{LAY_STD,  MODE_DIRECT,  4'd15, 1'b1, 30'h08888888, 4'd15},  // full count
        '{LAY_STD,  MODE_REVERSE, 4'd15, 1'b1, 30'h22222222, 4'd15},
        '{LAY_STD,  MODE_GROUP,   4'd2,  1'b0, '0, '0},               // two-chip group
        '{LAY_STD,  MODE_GROUP,   4'd15, 1'b0, '0, '0},
        '{LAY_STD,  MODE_SPREAD,  4'd15, 1'b0, '0, '0},
        '{LAY_LCR,  MODE_DIRECT,  4'd15, 1'b0, '0, '0},
        '{LAY_LCR,  MODE_REVERSE, 4'd14, 1'b0, '0, '0},
        '{LAY_LCR,  MODE_GROUP,   4'd9,  1'b0, '0, '0},               // one group
        '{LAY_LCR,  MODE_GROUP,   4'd10, 1'b0, '0, '0},               // split groups
        '{LAY_LCR,  MODE_SPREAD,  4'd15, 1'b0, '0, '0},
        '{LAY_CFST, MODE_DIRECT,  4'd15, 1'b0, '0, '0},
        '{LAY_CFST, MODE_REVERSE, 4'd11, 1'b0, '0, '0},               // center moved back
        '{LAY_CFST, MODE_GROUP,   4'd3,  1'b0, '0, '0},               // single L/R pair
        '{LAY_CFST, MODE_GROUP,   4'd9,  1'b0, '0, '0},               // runs of three
        '{LAY_CFST, MODE_GROUP,   4'd12, 1'b0, '0, '0},               // paired runs
        '{LAY_CFST, MODE_GROUP,   4'd15, 1'b0, '0, '0},               // three then pairs
        '{LAY_CFST, MODE_SPREAD,  4'd13, 1'b0, '0, '0}
    };

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         layout;
    logic [1:0]         mode;
    logic [3:0]         chip_count;
    logic               out_valid;
    logic               out_ready;
    logic [CODES_W-1:0] pan_codes;
    logic [3:0]         used_count;

    pan_result_t pending_maps [$];     // expected results, oldest first
    logic [1:0]  pan_slot [SLOTS];     // predictor's working slot map
    int          beats_sent;
    int          results_seen;
    int          mismatches;

    multi_chip_stereo_pan_map DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .layout     (layout),
        .mode       (mode),
        .chip_count (chip_count),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pan_codes  (pan_codes),
        .used_count (used_count)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Write a run of one code; slots past the end are dropped.
    function automatic void fill_slots(input int start, input int count,
                                       input logic [1:0] code);
        for (int k = 0; k < count; k++)
            if (start + k < SLOTS) pan_slot[start + k] = code;
    endfunction

    // Direct map, also the starting point of reverse mode.
    function automatic void lay_out_direct(input logic [1:0] lay, input int n);
        int cc;
        if (lay == LAY_STD) begin
            for (int k = 0; k < n; k++)
                fill_slots(k, 1, (k % 2) ? PAN_R : PAN_L);
        end
        else if (lay == LAY_LCR) begin
            for (int k = 0; k < n; k++)
                fill_slots(k, 1, (k % 3 == 0) ? PAN_L : (k % 3 == 1) ? PAN_C : PAN_R);
        end
        else begin
            // center block first, then L/R alternating
            cc = n - (n / 3) * 2;
            fill_slots(0, cc, PAN_C);
            for (int k = cc; k < n; k++)
                fill_slots(k, 1, ((k - cc) % 2) ? PAN_R : PAN_L);
        end
    endfunction

    function automatic pan_result_t pan_map_of(input logic [1:0] lay,
                                               input logic [1:0] md,
                                               input logic [3:0] cnt);
        int          n;
        int          lc;
        int          cc;
        int          pos;
        int          g;
        int          sz;
        int          rem;
        int          w;
        int          sizes [2];
        bit          left;
        logic [1:0]  tmp [SLOTS];
        pan_result_t r;

        n = cnt;
        if (n > MAX_CHIPS_DEF) n = MAX_CHIPS_DEF;
        if (n > SLOTS) n = SLOTS;
        for (int k = 0; k < SLOTS; k++) pan_slot[k] = PAN_NONE;

        if (n == 1 || (n >= 2 && lay == LAY_ALLC)) begin
            fill_slots(0, n, PAN_C);
        end
        else if (n >= 2) begin
            case (md)
                MODE_DIRECT: lay_out_direct(lay, n);
                MODE_REVERSE:
                begin
                    lay_out_direct(lay, n);
                    for (int k = 0; k < n; k++) begin
                        if (pan_slot[k] == PAN_L) pan_slot[k] = PAN_R;
                        else if (pan_slot[k] == PAN_R) pan_slot[k] = PAN_L;
                    end
                    // center-first: center entries move behind, order kept
                    if (lay == LAY_CFST) begin
                        w = 0;
                        for (int k = 0; k < n; k++)
                            if (pan_slot[k] != PAN_C) begin
                                tmp[w] = pan_slot[k];
                                w++;
                            end
                        for (int k = 0; k < n; k++)
                            if (pan_slot[k] == PAN_C) begin
                                tmp[w] = pan_slot[k];
                                w++;
                            end
                        for (int k = 0; k < w; k++) pan_slot[k] = tmp[k];
                    end
                end
                MODE_GROUP:
                begin
                    pos = 0;
                    if (lay == LAY_STD) begin
                        if (n == 2) begin
                            fill_slots(0, 1, PAN_L);
                            fill_slots(1, 1, PAN_R);
                        end
                        else begin
                            // pairs alternating sides, a lone slot at the end
                            left = 1'b1;
                            while (pos < n) begin
                                sz = (n - pos >= 2) ? 2 : 1;
                                fill_slots(pos, sz, left ? PAN_L : PAN_R);
                                pos += sz;
                                left = ~left;
                            end
                        end
                    end
                    else if (lay == LAY_LCR) begin
                        // one L-C-R group, or two once the count passes the split
                        sizes[0] = (n <= GROUP_SPLIT) ? n : GROUP_HEAD;
                        sizes[1] = n - sizes[0];
                        for (int gi = 0; gi < 2; gi++) begin
                            g = sizes[gi];
                            if (g != 0) begin
                                lc = (g + 1) / 3;
                                cc = g - 2 * lc;
                                fill_slots(pos, lc, PAN_L);
                                pos += lc;
                                fill_slots(pos, cc, PAN_C);
                                pos += cc;
                                fill_slots(pos, lc, PAN_R);
                                pos += lc;
                            end
                        end
                    end
                    else begin
                        lc = n / 3;
                        cc = n - 2 * lc;
                        fill_slots(0, cc, PAN_C);
                        pos = cc;
                        if (lc == 1) begin
                            fill_slots(pos, 1, PAN_L);
                            fill_slots(pos + 1, 1, PAN_R);
                        end
                        else if (lc > 0) begin
                            rem  = lc;
                            left = 1'b1;
                            // odd side count: lead with runs of three
                            if (lc % 2) begin
                                fill_slots(pos, TRIPLE_RUN, PAN_L);
                                pos += TRIPLE_RUN;
                                fill_slots(pos, TRIPLE_RUN, PAN_R);
                                pos += TRIPLE_RUN;
                                rem -= TRIPLE_RUN;
                            end
                            for (int k = 0; k < rem; k++) begin
                                fill_slots(pos, PAIR_COUNT, left ? PAN_L : PAN_R);
                                pos += PAIR_COUNT;
                                left = ~left;
                            end
                        end
                    end
                end
                default:
                begin
                    if (lay == LAY_STD) begin
                        lc = (n + 1) / 2;
                        fill_slots(0, lc, PAN_L);
                        fill_slots(lc, n - lc, PAN_R);
                    end
                    else begin
                        lc = n / 3;
                        cc = n - 2 * lc;
                        if (lay == LAY_LCR) begin
                            fill_slots(0, lc, PAN_L);
                            fill_slots(lc, cc, PAN_C);
                            fill_slots(lc + cc, lc, PAN_R);
                        end
                        else begin
                            fill_slots(0, cc, PAN_C);
                            fill_slots(cc, lc, PAN_L);
                            fill_slots(cc + lc, lc, PAN_R);
                        end
                    end
                end
            endcase
        end

        for (int k = 0; k < SLOTS; k++) r.codes[2 * k +: 2] = pan_slot[k];
        r.used = 4'(n);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one beat; push its expected result once it is taken. Gaps come
    // before valid rises, never while a beat is on offer.
    task automatic offer_beat(input logic [1:0] lay, input logic [1:0] md,
                              input logic [3:0] cnt, input pan_result_t want);
        bit steady;
        steady = (beats_sent >= STEADY_LO && beats_sent < STEADY_HI);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        layout     <= lay;
        mode       <= md;
        chip_count <= cnt;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_maps.push_back(want);
        beats_sent++;
    endtask

    // ------------------------------------------------------------------
    // Output side: check the beat taken at this edge, then pick ready for
    // the next one. Doing both in one process keeps the hold-off trigger
    // free of same-step ordering.
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string what, input logic [CODES_W-1:0] want_v,
                                 input logic [CODES_W-1:0] got_v);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want_v, got_v);
    endtask

    initial
    begin
        pan_result_t want;
        int          hold_left;
        bit          hold_done;
        bit          steady;

        hold_left = 0;
        hold_done = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                results_seen++;
                if (pending_maps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result beat with nothing pending, codes %h used %0d",
                                 $time, pan_codes, used_count);
                end
                else begin
                    want = pending_maps.pop_front();
                    if (pan_codes !== want.codes)
                        flag_mismatch("pan_codes", want.codes, pan_codes);
                    if (used_count !== want.used)
                        flag_mismatch("used_count", CODES_W'(want.used), CODES_W'(used_count));
                end
            end

            // long hold-off once, so the block backs up into its input
            steady = (results_seen >= STEADY_LO && results_seen < STEADY_HI);
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else if (steady)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: too long without a beat on either side ends the run.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout after %0d cycles without a beat", WATCHDOG);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, random beats, drain, verdict
    // ------------------------------------------------------------------
    initial
    begin
        stim_row_t   row;
        pan_result_t want;
        logic [1:0]  lay;
        logic [1:0]  md;
        logic [3:0]  cnt;

        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        layout       = LAY_STD;
        mode         = MODE_DIRECT;
        chip_count   = '0;
        out_ready    = 1'b0;
        beats_sent   = 0;
        results_seen = 0;
        mismatches   = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            row = DIRECTED_ROWS[i];
            if (row.known)
                want = '{codes: row.codes, used: row.used};
            else
                want = pan_map_of(row.lay, row.md, row.cnt);
            offer_beat(row.lay, row.md, row.cnt, want);
        end

        // no state carries over between items, so plain uniform fields cover every bit
        for (int i = 0; i < RANDOM_BEATS; i++) begin
            lay = 2'($urandom_range(0, 3));
            md  = 2'($urandom_range(0, 3));
            cnt = 4'($urandom_range(0, 15));
            offer_beat(lay, md, cnt, pan_map_of(lay, md, cnt));
        end
        in_valid <= 1'b0;

        while (pending_maps.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_maps.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
